>>> design/jls_pkg.sv
// Shared types and constants for the JPEG length scanner.
`timescale 1ns / 1ps

package jls_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 24;
   localparam int SIZE_WIDTH          = 24;
   localparam int CSR_INDEX_WIDTH     = 1;

   localparam logic [SIZE_WIDTH-1:0] SIZE_LIMIT_RESET     = 24'd6291456;
   localparam logic [SIZE_WIDTH-1:0] KEEP_THRESHOLD_RESET = 24'd0;
   localparam logic [SIZE_WIDTH-1:0] SIZE_MAX             = 24'hFFFFFF;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIZE_LIMIT     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEEP_THRESHOLD = 1'd1;

   // marker bytes
   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] BYTE_SOI  = 8'hD8;
   localparam logic [7:0] BYTE_EOI  = 8'hD9;
   localparam logic [7:0] BYTE_TEM  = 8'h01;
   localparam logic [7:0] BYTE_SOS  = 8'hDA;
   localparam logic [7:0] BYTE_RST0 = 8'hD0;
   localparam logic [7:0] BYTE_RST7 = 8'hD7;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_SOI    = 3'd1;
   localparam logic [2:0] ST_BAD_MARK  = 3'd2;
   localparam logic [2:0] ST_BAD_LEN   = 3'd3;
   localparam logic [2:0] ST_SCAN_LONG = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_candidate;
   } req_type;

   typedef struct packed {
      logic [SIZE_WIDTH-1:0] image_size;
      logic                  keep;
      logic [2:0]            status;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } step_out_type;

endpackage

>>> design/jpeg_length_scanner.sv
// Top level: input register, marker walker, result register and csr registers.
// The byte that ends or fails the candidate passes the input register, then the walker
// steps it into the result register, where rsp_valid rises; a waiting result holds it back.
// Throughput: one byte per cycle; a byte stalls only while a result waits on rsp_ready.
// Reset (synchronous, active high): walker idle, counters zero, both registers empty,
// size limit back to 6291456 and keep_threshold to 0.
`timescale 1ns / 1ps

module jpeg_length_scanner #(
   parameter int COUNT_WIDTH = jls_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  jls_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output jls_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [jls_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [jls_pkg::SIZE_WIDTH-1:0]        csr_data
);

   logic                            in_valid_ff;
   jls_pkg::req_type                in_ff;
   logic                            out_valid_ff;
   jls_pkg::rsp_type                out_ff;
   logic [jls_pkg::SIZE_WIDTH-1:0]  size_limit_ff;
   logic [jls_pkg::SIZE_WIDTH-1:0]  keep_threshold_ff;
   logic                            advance;
   jls_pkg::step_out_type           step_out;

   // step only when the result register can take whatever this byte produces
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign csr_ready = 1'b1;

   jls_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (in_ff),
      .size_limit     (size_limit_ff),
      .keep_threshold (keep_threshold_ff),
      .step_out       (step_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_out.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_out.emit) begin
         out_ff <= step_out.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff     <= jls_pkg::SIZE_LIMIT_RESET;
         keep_threshold_ff <= jls_pkg::KEEP_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            jls_pkg::CSR_SIZE_LIMIT:     size_limit_ff     <= csr_data;
            jls_pkg::CSR_KEEP_THRESHOLD: keep_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("walker advanced while a result was stalled");

   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(advance))
      else $error("result appeared without a byte step");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("held input byte lost");
`endif

endmodule

>>> design/jls_step.sv
// Marker segment walker: state registers and the per-byte next-state logic.
`timescale 1ns / 1ps

module jls_step #(
   parameter int COUNT_WIDTH = jls_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  jls_pkg::req_type                    item,
   input  logic [jls_pkg::SIZE_WIDTH-1:0]      size_limit,
   input  logic [jls_pkg::SIZE_WIDTH-1:0]      keep_threshold,
   output jls_pkg::step_out_type               step_out
);

   localparam int CMP_W = (COUNT_WIDTH > jls_pkg::SIZE_WIDTH) ? COUNT_WIDTH
                                                              : jls_pkg::SIZE_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_SOI     = 4'd1;
   localparam logic [3:0] PH_MARK    = 4'd2;
   localparam logic [3:0] PH_CODE    = 4'd3;
   localparam logic [3:0] PH_LEN_HI  = 4'd4;
   localparam logic [3:0] PH_LEN_LO  = 4'd5;
   localparam logic [3:0] PH_SKIP    = 4'd6;
   localparam logic [3:0] PH_SCAN    = 4'd7;
   localparam logic [3:0] PH_SCAN_FF = 4'd8;

   logic [3:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [15:0]            skip_count_ff, skip_count_in;
   logic [7:0]             length_high_ff, length_high_in;
   logic                   in_scan_ff, in_scan_in;

   logic [7:0]             b;
   logic [15:0]            seg_len;
   logic                   offset_over;
   logic                   len_bad;
   logic                   is_escape;
   logic                   emit;
   logic [2:0]             status;
   logic [CMP_W-1:0]       count_ext;
   logic [jls_pkg::SIZE_WIDTH-1:0] size_sat;

   assign b           = item.data_byte;
   assign seg_len     = {length_high_ff, b};
   assign offset_over = CMP_W'(byte_count_ff) >= CMP_W'(size_limit);
   assign len_bad     = (seg_len < 16'd2) || ({8'd0, seg_len} > size_limit);
   assign is_escape   = (b == jls_pkg::BYTE_ZERO) ||
                        ((b >= jls_pkg::BYTE_RST0) && (b <= jls_pkg::BYTE_RST7));

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      skip_count_in  = skip_count_ff;
      length_high_in = length_high_ff;
      in_scan_in     = in_scan_ff;
      emit           = 1'b0;
      status         = jls_pkg::ST_OK;
      if (item.start_candidate) begin
         phase_in       = PH_SOI;
         byte_count_in  = COUNT_ONE;
         skip_count_in  = 16'd0;
         length_high_in = 8'd0;
         in_scan_in     = 1'b0;
         if (b != jls_pkg::BYTE_FF) begin
            emit   = 1'b1;
            status = jls_pkg::ST_NO_SOI;
         end
      end else if (phase_ff != PH_IDLE) begin
         // saturate the byte counter
         if (byte_count_ff != COUNT_MAX) begin
            byte_count_in = byte_count_ff + COUNT_ONE;
         end
         unique case (phase_ff) inside
            PH_SOI: begin
               if (b != jls_pkg::BYTE_SOI) begin
                  emit   = 1'b1;
                  status = jls_pkg::ST_NO_SOI;
               end else begin
                  phase_in = PH_MARK;
               end
            end
            PH_MARK: begin
               if (b != jls_pkg::BYTE_FF) begin
                  emit   = 1'b1;
                  status = jls_pkg::ST_BAD_MARK;
               end else begin
                  phase_in = PH_CODE;
               end
            end
            PH_CODE, PH_SCAN_FF: begin
               if ((phase_ff == PH_SCAN_FF) && is_escape) begin
                  if (offset_over) begin
                     emit   = 1'b1;
                     status = jls_pkg::ST_SCAN_LONG;
                  end else begin
                     phase_in = PH_SCAN;
                  end
               end else if (b == jls_pkg::BYTE_EOI) begin
                  emit   = 1'b1;
                  status = jls_pkg::ST_OK;
               end else if ((b == jls_pkg::BYTE_TEM) || (b == jls_pkg::BYTE_FF)) begin
                  phase_in = PH_MARK;
               end else begin
                  in_scan_in = (b == jls_pkg::BYTE_SOS);
                  phase_in   = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               length_high_in = b;
               phase_in       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (len_bad) begin
                  emit   = 1'b1;
                  status = jls_pkg::ST_BAD_LEN;
               end else begin
                  skip_count_in = seg_len - 16'd2;
                  if (seg_len != 16'd2) begin
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = in_scan_ff ? PH_SCAN : PH_MARK;
                  end
               end
            end
            PH_SKIP: begin
               skip_count_in = skip_count_ff - 16'd1;
               if (skip_count_ff == 16'd1) begin
                  phase_in = in_scan_ff ? PH_SCAN : PH_MARK;
               end
            end
            PH_SCAN: begin
               if (offset_over) begin
                  emit   = 1'b1;
                  status = jls_pkg::ST_SCAN_LONG;
               end else if (b == jls_pkg::BYTE_FF) begin
                  phase_in = PH_SCAN_FF;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   // image size counts up to and including the end marker, clipped to 24 bits
   always_comb begin
      count_ext = CMP_W'(byte_count_in);
      if (count_ext > CMP_W'(jls_pkg::SIZE_MAX)) begin
         size_sat = jls_pkg::SIZE_MAX;
      end else begin
         size_sat = count_ext[jls_pkg::SIZE_WIDTH-1:0];
      end
   end

   always_comb begin
      step_out.emit       = emit;
      step_out.rsp.status = status;
      if (status == jls_pkg::ST_OK) begin
         step_out.rsp.image_size = size_sat;
         step_out.rsp.keep       = size_sat > keep_threshold;
      end else begin
         step_out.rsp.image_size = '0;
         step_out.rsp.keep       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_count_ff  <= '0;
         skip_count_ff  <= '0;
         length_high_ff <= '0;
         in_scan_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         skip_count_ff  <= skip_count_in;
         length_high_ff <= length_high_in;
         in_scan_ff     <= in_scan_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> phase_ff == PH_IDLE)
      else $error("phase not idle after a result");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_count_ff != 16'd0)
      else $error("skip phase with nothing left to skip");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_IDLE && !item.start_candidate |-> !emit)
      else $error("result from an idle scanner");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      emit && status != jls_pkg::ST_OK |->
         step_out.rsp.image_size == '0 && !step_out.rsp.keep)
      else $error("failed result carries size or keep");
`endif

endmodule

>>> tb/jpeg_length_scanner_tb.sv
// Self-checking testbench for the JPEG length scanner: random candidate streams, marker-walk predictor.
`timescale 1ns / 1ps

module jpeg_length_scanner_tb;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int BYTES_PER_STEP = 160;
   localparam int NUM_STEPS      = 8;
   localparam int SETTLE_CYCLES  = 8;

   localparam logic [jls_pkg::SIZE_WIDTH-1:0] SIZE_LIMIT_STEPS [NUM_STEPS] = '{
      jls_pkg::SIZE_LIMIT_RESET, 24'd40, 24'd2, jls_pkg::SIZE_MAX, 24'd0, 24'd120,
      24'd16, 24'd300};
   localparam logic [jls_pkg::SIZE_WIDTH-1:0] THRESHOLD_STEPS [NUM_STEPS] = '{
      jls_pkg::KEEP_THRESHOLD_RESET, 24'd12, jls_pkg::SIZE_MAX, 24'd0, 24'd30, 24'd40,
      24'd5, 24'd25};

   typedef enum logic [3:0] {
      WALK_IDLE, WALK_SOI, WALK_MARK, WALK_CODE, WALK_LEN_HI,
      WALK_LEN_LO, WALK_SKIP, WALK_SCAN, WALK_SCAN_FF
   } walk_state_type;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   jls_pkg::req_type                    req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   jls_pkg::rsp_type                    rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [jls_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [jls_pkg::SIZE_WIDTH-1:0]      csr_data  = '0;

   jls_pkg::req_type pending_bytes[$];
   jls_pkg::rsp_type pending_verdicts[$];
   logic [7:0]       candidate_bytes[$];
   jls_pkg::rsp_type predicted_verdict;
   jls_pkg::rsp_type oldest_verdict;

   int error_count  = 0;
   int cycle_count  = 0;
   int step_bytes   = 0;
   int burst_left   = 0;
   int gap_left     = 0;
   int stall_mode   = 0;
   int stall_timer  = 0;

   // predictor copy of the block's configuration and walk state
   logic [jls_pkg::SIZE_WIDTH-1:0] cfg_size_limit     = jls_pkg::SIZE_LIMIT_RESET;
   logic [jls_pkg::SIZE_WIDTH-1:0] cfg_keep_threshold = jls_pkg::KEEP_THRESHOLD_RESET;
   walk_state_type                 walk_state  = WALK_IDLE;
   logic [jls_pkg::SIZE_WIDTH-1:0] walk_count  = '0;
   logic [15:0]                    walk_skip   = '0;
   logic [7:0]                     walk_len_hi = '0;
   logic                           walk_in_sos = 1'b0;

   jpeg_length_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit marker_ends_image(input logic [7:0] code);
      if (code == jls_pkg::BYTE_EOI) return 1'b1;
      if (code == jls_pkg::BYTE_TEM || code == jls_pkg::BYTE_FF) begin
         walk_state = WALK_MARK;
      end else begin
         walk_in_sos = (code == jls_pkg::BYTE_SOS);
         walk_state  = WALK_LEN_HI;
      end
      return 1'b0;
   endfunction

   // Advance the walk by one byte; return 1 when the candidate completes or fails.
   function automatic bit scan_byte(input jls_pkg::req_type item,
                                    output jls_pkg::rsp_type verdict);
      logic [7:0]                     b;
      logic [jls_pkg::SIZE_WIDTH-1:0] offset;
      logic [15:0]                    seg_len;
      logic [2:0]                     status;
      bit                             done;
      b       = item.data_byte;
      offset  = walk_count;
      seg_len = {walk_len_hi, b};
      status  = jls_pkg::ST_OK;
      done    = 1'b0;
      verdict = '0;
      if (item.start_candidate) begin
         walk_count  = jls_pkg::SIZE_WIDTH'(1);
         walk_skip   = '0;
         walk_len_hi = '0;
         walk_in_sos = 1'b0;
         walk_state  = WALK_SOI;
         if (b != jls_pkg::BYTE_FF) begin
            done   = 1'b1;
            status = jls_pkg::ST_NO_SOI;
         end
      end else if (walk_state != WALK_IDLE) begin
         if (walk_count != jls_pkg::SIZE_MAX) walk_count++;
         case (walk_state)
            WALK_SOI: begin
               if (b != jls_pkg::BYTE_SOI) begin
                  done   = 1'b1;
                  status = jls_pkg::ST_NO_SOI;
               end else walk_state = WALK_MARK;
            end
            WALK_MARK: begin
               if (b != jls_pkg::BYTE_FF) begin
                  done   = 1'b1;
                  status = jls_pkg::ST_BAD_MARK;
               end else walk_state = WALK_CODE;
            end
            WALK_CODE: done = marker_ends_image(b);
            WALK_LEN_HI: begin
               walk_len_hi = b;
               walk_state  = WALK_LEN_LO;
            end
            WALK_LEN_LO: begin
               if (seg_len < 16'd2 || {8'd0, seg_len} > cfg_size_limit) begin
                  done   = 1'b1;
                  status = jls_pkg::ST_BAD_LEN;
               end else begin
                  walk_skip = seg_len - 16'd2;
                  if (walk_skip != 16'd0) walk_state = WALK_SKIP;
                  else walk_state = walk_in_sos ? WALK_SCAN : WALK_MARK;
               end
            end
            WALK_SKIP: begin
               walk_skip--;
               if (walk_skip == 16'd0) walk_state = walk_in_sos ? WALK_SCAN : WALK_MARK;
            end
            WALK_SCAN: begin
               if (offset >= cfg_size_limit) begin
                  done   = 1'b1;
                  status = jls_pkg::ST_SCAN_LONG;
               end else if (b == jls_pkg::BYTE_FF) walk_state = WALK_SCAN_FF;
            end
            WALK_SCAN_FF: begin
               // stuffed zero and restart codes stay inside the scan
               if (b == jls_pkg::BYTE_ZERO ||
                   (b >= jls_pkg::BYTE_RST0 && b <= jls_pkg::BYTE_RST7)) begin
                  if (offset >= cfg_size_limit) begin
                     done   = 1'b1;
                     status = jls_pkg::ST_SCAN_LONG;
                  end else walk_state = WALK_SCAN;
               end else done = marker_ends_image(b);
            end
            default: walk_state = WALK_IDLE;
         endcase
      end
      if (done) begin
         if (status == jls_pkg::ST_OK) begin
            verdict.image_size = walk_count;
            verdict.keep       = (walk_count > cfg_keep_threshold);
         end
         verdict.status = status;
         walk_state     = WALK_IDLE;
      end
      return done;
   endfunction

   function automatic void queue_byte(input logic [7:0] value, input logic first);
      jls_pkg::req_type item;
      item.data_byte       = value;
      item.start_candidate = first;
      pending_bytes.push_back(item);
   endfunction

   task automatic queue_candidate();
      foreach (candidate_bytes[i]) queue_byte(candidate_bytes[i], i == 0);
      step_bytes += candidate_bytes.size();
      candidate_bytes.delete();
   endtask

   task automatic wait_idle();
      do begin
         while (pending_bytes.size() != 0 || req_valid || pending_verdicts.size() != 0)
            @(posedge clock);
         // let bytes that give no result drain out of the pipeline
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (pending_bytes.size() != 0 || req_valid || pending_verdicts.size() != 0);
   endtask

   task automatic write_csr(input logic [jls_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [jls_pkg::SIZE_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == jls_pkg::CSR_SIZE_LIMIT) cfg_size_limit = value;
      else cfg_keep_threshold = value;
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (scan_byte(req_data, predicted_verdict))
               pending_verdicts.push_back(predicted_verdict);
         end
         // hold the payload until the transfer
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_bytes.pop_front();
               if (burst_left <= 1) begin
                  if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
                  else burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else burst_left--;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result against the oldest prediction, stalls in windows.
   always @(posedge clock) begin : result_monitor
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_timer = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result: image_size %0d keep %0d status %0d",
                      rsp_data.image_size, rsp_data.keep, rsp_data.status);
               error_count++;
            end else begin
               oldest_verdict = pending_verdicts.pop_front();
               if (rsp_data.image_size !== oldest_verdict.image_size) begin
                  $error("image_size: expected %0d, actual %0d",
                         oldest_verdict.image_size, rsp_data.image_size);
                  error_count++;
               end
               if (rsp_data.keep !== oldest_verdict.keep) begin
                  $error("keep: expected %0d, actual %0d", oldest_verdict.keep, rsp_data.keep);
                  error_count++;
               end
               if (rsp_data.status !== oldest_verdict.status) begin
                  $error("status: expected %0d, actual %0d",
                         oldest_verdict.status, rsp_data.status);
                  error_count++;
               end
            end
         end
         if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(8, 40);
         end else stall_timer--;
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 2) == 0);
            default: rsp_ready <= (stall_timer == 0);
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int          pick;
      int          kind;
      int          where;
      logic [7:0]  code;
      logic [15:0] seg_len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: minimal image, abandoned candidate, scan with escapes and FF FF,
      // bad first byte, stray byte while idle
      candidate_bytes = {jls_pkg::BYTE_FF, jls_pkg::BYTE_SOI, jls_pkg::BYTE_FF,
                         jls_pkg::BYTE_EOI};
      queue_candidate();
      candidate_bytes = {jls_pkg::BYTE_FF, jls_pkg::BYTE_SOI, jls_pkg::BYTE_FF, 8'hC4};
      queue_candidate();
      candidate_bytes = {jls_pkg::BYTE_FF, jls_pkg::BYTE_SOI, jls_pkg::BYTE_FF,
                         jls_pkg::BYTE_SOS, 8'h00, 8'h02, 8'h12,
                         jls_pkg::BYTE_FF, jls_pkg::BYTE_ZERO, jls_pkg::BYTE_FF,
                         jls_pkg::BYTE_RST7, jls_pkg::BYTE_FF, jls_pkg::BYTE_FF,
                         jls_pkg::BYTE_FF, jls_pkg::BYTE_EOI};
      queue_candidate();
      queue_byte(8'h3C, 1'b1);
      queue_byte(8'h7E, 1'b0);

      for (int step = 0; step < NUM_STEPS; step++) begin
         if (step != 0) begin
            wait_idle();
            write_csr(jls_pkg::CSR_SIZE_LIMIT, SIZE_LIMIT_STEPS[step]);
            write_csr(jls_pkg::CSR_KEEP_THRESHOLD, THRESHOLD_STEPS[step]);
         end
         step_bytes = 0;
         while (step_bytes < BYTES_PER_STEP) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               // stray bytes without a start
               repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick == 1) begin
               queue_byte(8'($urandom_range(0, 254)), 1'b1);
               step_bytes++;
            end else begin
               candidate_bytes = {jls_pkg::BYTE_FF, jls_pkg::BYTE_SOI};
               repeat ($urandom_range(0, 3)) begin
                  kind = $urandom_range(0, 3);
                  if (kind == 0) begin
                     candidate_bytes.push_back(jls_pkg::BYTE_FF);
                     candidate_bytes.push_back($urandom_range(0, 1) ? jls_pkg::BYTE_TEM
                                                                    : jls_pkg::BYTE_FF);
                  end else begin
                     if (kind == 1) begin
                        do code = 8'($urandom_range(0, 255));
                        while (code == jls_pkg::BYTE_EOI || code == jls_pkg::BYTE_TEM ||
                               code == jls_pkg::BYTE_FF || code == jls_pkg::BYTE_SOS ||
                               code == jls_pkg::BYTE_ZERO ||
                               (code >= jls_pkg::BYTE_RST0 && code <= jls_pkg::BYTE_RST7));
                     end else code = jls_pkg::BYTE_SOS;
                     if ($urandom_range(0, 11) == 0) seg_len = 16'($urandom_range(11, 200));
                     else seg_len = 16'($urandom_range(2, 10));
                     candidate_bytes.push_back(jls_pkg::BYTE_FF);
                     candidate_bytes.push_back(code);
                     candidate_bytes.push_back(seg_len[15:8]);
                     candidate_bytes.push_back(seg_len[7:0]);
                     repeat (seg_len - 2) candidate_bytes.push_back(8'($urandom_range(0, 255)));
                     if (code == jls_pkg::BYTE_SOS) begin
                        repeat ($urandom_range(0, 30)) begin
                           if ($urandom_range(0, 7) == 0) begin
                              candidate_bytes.push_back(jls_pkg::BYTE_FF);
                              if ($urandom_range(0, 1) == 0)
                                 candidate_bytes.push_back(jls_pkg::BYTE_ZERO);
                              else candidate_bytes.push_back(
                                 8'($urandom_range(jls_pkg::BYTE_RST0, jls_pkg::BYTE_RST7)));
                           end else candidate_bytes.push_back(8'($urandom_range(0, 254)));
                        end
                     end
                  end
               end
               candidate_bytes.push_back(jls_pkg::BYTE_FF);
               candidate_bytes.push_back(jls_pkg::BYTE_EOI);
               if (pick >= 16) begin
                  // break the image: overwrite, cut short, or insert a byte
                  where = $urandom_range(0, candidate_bytes.size() - 1);
                  case ($urandom_range(0, 2))
                     0: candidate_bytes[where] = 8'($urandom_range(0, 255));
                     1: while (candidate_bytes.size() > where + 1)
                           void'(candidate_bytes.pop_back());
                     default: candidate_bytes.insert(where, 8'($urandom_range(0, 255)));
                  endcase
               end
               queue_candidate();
            end
         end
      end

      wait_idle();
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
